### rtl/core/midi_track_event_parser_defines.svh
// Assertion macros for the track event parser.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`define MIDI_TRACK_EVENT_PARSER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MTEP_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define MTEP_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTEP_ASSERT(label, clk, rstn, prop, msg)
`define MTEP_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

### rtl/core/mtep_pkg.sv
// Shared types, codes and constants for the track event parser.
// No dependencies.
package mtep_pkg;

    localparam int MaxVlqBytes = 16;
    localparam int NumChannels = 16;
    localparam int VlqCntW     = $clog2(MaxVlqBytes + 1);

    // Result kinds
    localparam logic [2:0] KIND_CHAN    = 3'd0;
    localparam logic [2:0] KIND_SYX     = 3'd1;
    localparam logic [2:0] KIND_META    = 3'd2;
    localparam logic [2:0] KIND_PAYLOAD = 3'd3;
    localparam logic [2:0] KIND_SYXEND  = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;
    localparam logic [2:0] KIND_ERROR   = 3'd6;

    // Parser phases
    localparam logic [3:0] PH_DELTA    = 4'd0;
    localparam logic [3:0] PH_STATUS   = 4'd1;
    localparam logic [3:0] PH_DATA_A   = 4'd2;
    localparam logic [3:0] PH_DATA_B   = 4'd3;
    localparam logic [3:0] PH_SYSLEN   = 4'd4;
    localparam logic [3:0] PH_SYSDATA  = 4'd5;
    localparam logic [3:0] PH_METATYPE = 4'd6;
    localparam logic [3:0] PH_METALEN  = 4'd7;
    localparam logic [3:0] PH_METADATA = 4'd8;

    localparam logic [7:0] META_CHANNEL = 8'h20;
    localparam logic [7:0] META_PORT    = 8'h21;
    localparam logic [7:0] META_EOT     = 8'h2f;

    // One result transaction
    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        tick;
        logic [3:0]         status_type;
        logic [3:0]         channel;
        logic [7:0]         port;
        logic [6:0]         data_a;
        logic [6:0]         data_b;
        logic signed [13:0] bend_value;
        logic [7:0]         meta_type;
        logic [31:0]        length;
        logic [7:0]         payload;
        logic               last;
    } result_t;

    // Queue depth between front and back
    localparam int QDepth = 2;

endpackage

### rtl/core/mtep_front.sv
// Front end: parses track bytes, one a cycle while the result queue has room.
// Depends on mtep_pkg; produces result_t transactions for the queue.
`include "midi_track_event_parser_defines.svh"
module mtep_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       data_byte,
    input  logic             new_track,
    output logic             res_valid,
    output mtep_pkg::result_t res,
    input  logic             res_ready
);
    import mtep_pkg::*;

    logic [3:0]  phase_reg, phase_next;
    logic [8:0]  run_reg, run_next, saved_reg, saved_next;
    logic [31:0] tick_reg, tick_next, acc_reg, acc_next, left_reg, left_next;
    logic [VlqCntW-1:0] cnt_reg, cnt_next;
    logic [6:0]  held_a_reg, held_a_next;
    logic [7:0]  mtype_reg, mtype_next, port_reg, port_next;
    logic [3:0]  chan_reg, chan_next;
    logic [1:0]  stop_reg, stop_next;

    logic        take;
    logic        emit;
    result_t     r;

    // working copies after an optional track restart
    logic [3:0]  ph0;
    logic [8:0]  run0, sav0;
    logic [31:0] tick0, acc0, left0;
    logic [VlqCntW-1:0] cnt0;
    logic [7:0]  port0, c;
    logic [3:0]  chan0;
    logic [1:0]  stop0;
    logic [31:0] vacc, left_dec;
    logic [VlqCntW-1:0] vcnt;
    logic        vdone, vlong;
    logic [3:0]  ftype;
    logic [6:0]  b7;
    logic [13:0] bendraw;

    assign in_ready = res_ready;
    assign take     = in_valid && in_ready;
    assign res_valid = take && emit;
    assign res = r;

    always_comb begin
        c     = data_byte;
        ph0   = new_track ? PH_DELTA : phase_reg;
        run0  = new_track ? 9'h100 : run_reg;
        sav0  = new_track ? 9'h100 : saved_reg;
        tick0 = new_track ? 32'd0 : tick_reg;
        acc0  = new_track ? 32'd0 : acc_reg;
        cnt0  = new_track ? '0 : cnt_reg;
        left0 = new_track ? 32'd0 : left_reg;
        port0 = new_track ? 8'd0 : port_reg;
        chan0 = new_track ? 4'd0 : chan_reg;
        stop0 = new_track ? 2'd0 : stop_reg;

        vacc  = {acc0[24:0], c[6:0]};
        vcnt  = cnt0 + 1'b1;
        vdone = !c[7];
        vlong = c[7] && (vcnt >= VlqCntW'(MaxVlqBytes));
        left_dec = left0 - 32'd1;

        phase_next = ph0; run_next = run0; saved_next = sav0; tick_next = tick0;
        acc_next = acc0; cnt_next = cnt0; left_next = left0;
        held_a_next = held_a_reg; mtype_next = mtype_reg;
        port_next = port0; chan_next = chan0; stop_next = stop0;
        emit = 1'b0;
        r = '0;
        r.tick = tick0;
        r.channel = chan0;
        r.port = port0;
        r.last = 1'b1;
        ftype = run0[7:4];
        b7 = 7'd0;
        bendraw = 14'd0;

        if (stop0 == 2'd0) begin
            case (ph0)
                PH_DELTA: begin
                    acc_next = vacc; cnt_next = vcnt;
                    if (vdone) begin
                        tick_next = tick0 + vacc;
                        phase_next = PH_STATUS;
                    end else if (vlong) begin
                        stop_next = 2'd1;
                        emit = 1'b1;
                        r.kind = KIND_END;
                    end
                end
                PH_STATUS: begin
                    if (c >= 8'hf8 && c <= 8'hfe) begin
                        phase_next = PH_STATUS;
                    end else if (c == 8'hf0 || c == 8'hf7) begin
                        run_next = 9'h100; phase_next = PH_SYSLEN;
                        acc_next = '0; cnt_next = '0;
                    end else if (c == 8'hff) begin
                        run_next = 9'h100; phase_next = PH_METATYPE;
                    end else if (c >= 8'hf0) begin
                        phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                    end else if (c[7]) begin
                        run_next = {1'b0, c}; saved_next = {1'b0, c};
                        phase_next = PH_DATA_A;
                    end else if (run0[8] && sav0[8]) begin
                        phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                    end else begin
                        if (run0[8]) begin
                            run_next = sav0;
                            ftype = sav0[7:4];
                        end
                        phase_next = PH_DATA_A; // resolved below
                    end
                end
                PH_DATA_A: phase_next = PH_DATA_A;
                PH_DATA_B: begin
                    b7 = c[7] ? 7'd0 : c[6:0];
                    bendraw = {b7, held_a_reg} ^ 14'h2000;
                    chan_next = run0[3:0];
                    if (c[7]) begin
                        run_next = {1'b0, c & 8'hf0}; saved_next = {1'b0, c & 8'hf0};
                    end
                    phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                    emit = 1'b1;
                    r.kind = KIND_CHAN; r.status_type = run0[7:4];
                    r.channel = run0[3:0]; r.data_a = held_a_reg; r.data_b = b7;
                    r.bend_value = (run0[7:4] == 4'd14) ? bendraw : 14'sd0;
                end
                PH_SYSLEN, PH_METALEN: begin
                    acc_next = vacc; cnt_next = vcnt;
                    if (vlong) begin
                        stop_next = 2'd2; emit = 1'b1; r.kind = KIND_ERROR;
                    end else if (vdone) begin
                        left_next = vacc;
                        if (ph0 == PH_SYSLEN) begin
                            emit = 1'b1; r.kind = KIND_SYX; r.length = vacc;
                            r.last = (vacc == 32'd0);
                            if (vacc == 32'd0) begin
                                phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                            end else begin
                                phase_next = PH_SYSDATA;
                            end
                        end else if (mtype_reg == META_EOT) begin
                            if (vacc == 32'd0) begin
                                stop_next = 2'd1; emit = 1'b1; r.kind = KIND_END;
                                r.meta_type = META_EOT;
                            end else begin
                                phase_next = PH_METADATA;
                            end
                        end else begin
                            emit = 1'b1; r.kind = KIND_META; r.meta_type = mtype_reg;
                            r.length = vacc; r.last = (vacc == 32'd0);
                            if (vacc == 32'd0) begin
                                if (mtype_reg == META_PORT) port_next = 8'd0;
                                else if (mtype_reg == META_CHANNEL) chan_next = 4'd0;
                                // result carries the updated channel and port
                                r.channel = chan_next; r.port = port_next;
                                phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                            end else begin
                                phase_next = PH_METADATA;
                            end
                        end
                    end
                end
                PH_SYSDATA: begin
                    left_next = left_dec; emit = 1'b1;
                    r.length = acc0; r.payload = c;
                    r.last = (left_dec == 32'd0);
                    r.kind = (left_dec == 32'd0 && c == 8'hf7) ? KIND_SYXEND : KIND_PAYLOAD;
                    if (left_dec == 32'd0) begin
                        phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                    end
                end
                PH_METATYPE: begin
                    mtype_next = c; phase_next = PH_METALEN;
                    acc_next = '0; cnt_next = '0;
                end
                PH_METADATA: begin
                    left_next = left_dec;
                    if (mtype_reg == META_EOT) begin
                        if (left_dec == 32'd0) begin
                            stop_next = 2'd1; emit = 1'b1; r.kind = KIND_END;
                            r.meta_type = META_EOT; r.length = acc0;
                        end
                    end else begin
                        if (left0 == acc0) begin
                            if (mtype_reg == META_PORT) port_next = c;
                            else if (mtype_reg == META_CHANNEL)
                                chan_next = (c >= 8'(NumChannels)) ? 4'd0 : c[3:0];
                        end
                        // result carries the updated channel and port
                        r.channel = chan_next; r.port = port_next;
                        emit = 1'b1; r.kind = KIND_PAYLOAD; r.meta_type = mtype_reg;
                        r.length = acc0; r.payload = c; r.last = (left_dec == 32'd0);
                        if (left_dec == 32'd0) begin
                            phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                        end
                    end
                end
                default: begin
                    phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                end
            endcase

            // first data byte, shared by data-A phase and running status
            if (ph0 == PH_DATA_A || (ph0 == PH_STATUS && !c[7] && !(run0[8] && sav0[8]))) begin
                if (ph0 == PH_DATA_A) ftype = run0[7:4];
                if (ftype == 4'd8 || ftype == 4'd9 || ftype == 4'd10 || ftype == 4'd11
                    || ftype == 4'd14) begin
                    held_a_next = c[6:0]; phase_next = PH_DATA_B;
                end else if (ftype == 4'd12 || ftype == 4'd13) begin
                    chan_next = run_next[3:0];
                    phase_next = PH_DELTA; acc_next = '0; cnt_next = '0;
                    emit = 1'b1; r.kind = KIND_CHAN; r.status_type = ftype;
                    r.channel = run_next[3:0]; r.data_a = c[6:0];
                end else begin
                    stop_next = 2'd2; emit = 1'b1; r = '0; r.kind = KIND_ERROR;
                    r.tick = tick0; r.channel = chan0; r.port = port0; r.last = 1'b1;
                end
            end
        end
    end

    // parser state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_DELTA; run_reg <= 9'h100; saved_reg <= 9'h100;
            tick_reg <= '0; acc_reg <= '0; cnt_reg <= '0; left_reg <= '0;
            held_a_reg <= '0; mtype_reg <= '0; chan_reg <= '0; port_reg <= '0;
            stop_reg <= '0;
        end else if (take) begin
            phase_reg <= phase_next; run_reg <= run_next; saved_reg <= saved_next;
            tick_reg <= tick_next; acc_reg <= acc_next; cnt_reg <= cnt_next;
            left_reg <= left_next; held_a_reg <= held_a_next; mtype_reg <= mtype_next;
            chan_reg <= chan_next; port_reg <= port_next; stop_reg <= stop_next;
        end
    end

    `MTEP_ASSERT(a_stop_quiet, aclk, aresetn,
        (take && !new_track && stop_reg != 2'd0) |-> !res_valid,
        "result after track stop")
    `MTEP_ASSERT(a_phase_legal, aclk, aresetn, phase_reg <= PH_METADATA,
        "phase out of range")
    `MTEP_ASSERT(a_vlq_bound, aclk, aresetn, cnt_reg <= VlqCntW'(MaxVlqBytes),
        "vlq count overflow")
endmodule

### rtl/core/mtep_queue.sv
// Back end: short result queue that decouples the parser from the output.
// Depends on mtep_pkg.
`include "midi_track_event_parser_defines.svh"
module mtep_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  mtep_pkg::result_t wr_data,
    output logic              rd_valid,
    input  logic              rd_ready,
    output mtep_pkg::result_t rd_data
);
    import mtep_pkg::*;

    result_t          mem_reg [QDepth];
    logic             wp_reg, rp_reg;
    logic [1:0]       cnt_reg;
    logic             push, pop;

    assign wr_ready = (cnt_reg != 2'(QDepth));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign push = wr_valid && wr_ready;
    assign pop  = rd_valid && rd_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= wr_data;
    end

    // pointers and fill
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end

    `MTEP_ASSERT(a_q_bound, aclk, aresetn, cnt_reg <= 2'(QDepth), "queue overfill")
    `MTEP_ASSERT(a_q_ptr, aclk, aresetn,
        (cnt_reg == 2'd0 || cnt_reg == 2'(QDepth)) |-> (wp_reg == rp_reg),
        "queue pointers disagree with fill")
    `MTEP_ASSERT_RST(a_q_reset, aclk, !aresetn |=> (cnt_reg == 2'd0), "queue not empty after reset")
endmodule

### rtl/core/midi_track_event_parser.sv
// Track event parser top level: a parsing front end feeding a two-entry result queue.
// Depends on mtep_pkg, mtep_front and mtep_queue.
//
// One track byte is taken per cycle whenever the result queue has room, and each
// byte produces zero or one result, written to the queue and offered from the next
// cycle at the earliest; throughput is one byte per cycle while m_ready keeps up.
// Reset is synchronous; new_track restarts the parser with the byte.
module midi_track_event_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [7:0]         s_data_byte,
    input  logic               s_new_track,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_kind,
    output logic [31:0]        m_tick,
    output logic [3:0]         m_status_type,
    output logic [3:0]         m_channel,
    output logic [7:0]         m_port,
    output logic [6:0]         m_data_a,
    output logic [6:0]         m_data_b,
    output logic signed [13:0] m_bend_value,
    output logic [7:0]         m_meta_type,
    output logic [31:0]        m_length,
    output logic [7:0]         m_payload,
    output logic               m_last
);
    import mtep_pkg::*;

    result_t fr, qo;
    logic    fv, fr_ready;

    mtep_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .data_byte(s_data_byte), .new_track(s_new_track),
        .res_valid(fv), .res(fr), .res_ready(fr_ready)
    );

    mtep_queue u_queue (
        .aclk(aclk), .aresetn(aresetn), .wr_valid(fv), .wr_ready(fr_ready),
        .wr_data(fr), .rd_valid(m_valid), .rd_ready(m_ready), .rd_data(qo)
    );

    assign m_kind = qo.kind;
    assign m_tick = qo.tick;
    assign m_status_type = qo.status_type;
    assign m_channel = qo.channel;
    assign m_port = qo.port;
    assign m_data_a = qo.data_a;
    assign m_data_b = qo.data_b;
    assign m_bend_value = qo.bend_value;
    assign m_meta_type = qo.meta_type;
    assign m_length = qo.length;
    assign m_payload = qo.payload;
    assign m_last = qo.last;
endmodule
